FILE: src/escaped_byte_channel_mux_core_macros.svh
// assertion macros for the escaped byte channel mux core
// included by the top level, needs nothing else
`ifndef ESCAPED_BYTE_CHANNEL_MUX_CORE_MACROS_SVH
`define ESCAPED_BYTE_CHANNEL_MUX_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every edge outside reset
`define EBCM_ASSERT(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);
// property checked at every edge, reset included
`define EBCM_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define EBCM_ASSERT(lbl, clk_i, rst_i, prop, msg)
`define EBCM_ASSERT_ALWAYS(lbl, clk_i, prop, msg)
`endif

`endif

FILE: src/ebcm_pkg.sv
// shared types and constants of the escaped byte channel mux core
// used by ebcm_rx, ebcm_tx and the top level; depends on nothing
package ebcm_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam logic [7:0] LINK_START = 8'h02;
  localparam logic [7:0] LINK_ESC   = 8'h1B;
  localparam logic [7:0] ESC_XOR    = 8'h40;

  // configuration register indexes
  typedef enum logic {
    REG_RX_MASK = 1'b0,
    REG_TX_MASK = 1'b1
  } reg_index_t;

  // transmit frame phase
  typedef enum logic [1:0] {
    TX_IDLE   = 2'd0,  // no frame open, start next
    TX_HEADER = 2'd1,  // header owed
    TX_DATA   = 2'd2,  // escape and/or data owed
    TX_OPEN   = 2'd3   // frame open, ready for a new byte
  } tx_phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] link_byte_in;
    logic       src_has_data;
    logic [7:0] src_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] channel;
    logic [7:0] data;
    logic       is_header;
  } deliver_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } send_t;

endpackage

FILE: src/ebcm_rx.sv
// receive deframer: start/escape decoding, header capture, channel gating
// depends on ebcm_pkg
module ebcm_rx #(
  parameter int NUM_CHANNELS = ebcm_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        link_byte_in,
  input  logic [7:0]        rx_enable_mask,
  output ebcm_pkg::deliver_t deliver
);

  logic [2:0] rx_chan, rx_chan_next;
  logic       rx_escape, rx_escape_next;
  logic       rx_header_seen, rx_header_seen_next;
  logic       rx_chan_ok, rx_chan_ok_next;

  always_comb begin
    logic [7:0] b;
    logic       hdr;
    rx_chan_next        = rx_chan;
    rx_escape_next      = rx_escape;
    rx_header_seen_next = rx_header_seen;
    rx_chan_ok_next     = rx_chan_ok;
    deliver             = '0;
    b                   = rx_escape ? (link_byte_in ^ ebcm_pkg::ESC_XOR) : link_byte_in;
    hdr                 = !rx_header_seen;
    if (step) begin
      if (link_byte_in == ebcm_pkg::LINK_START) begin
        rx_header_seen_next = 1'b0;
        rx_escape_next      = 1'b0;
      end else if (link_byte_in == ebcm_pkg::LINK_ESC) begin
        rx_escape_next = 1'b1;
      end else begin
        rx_escape_next = 1'b0;
        if (hdr) begin
          rx_chan_next        = b[7:5];
          rx_chan_ok_next     = ({1'b0, b[7:5]} < 4'(NUM_CHANNELS));
          rx_header_seen_next = 1'b1;
        end
        if (rx_chan_ok_next && rx_enable_mask[rx_chan_next]) begin
          deliver.valid     = 1'b1;
          deliver.channel   = rx_chan_next;
          deliver.data      = b;
          deliver.is_header = hdr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_chan        <= '0;
      rx_escape      <= 1'b0;
      rx_header_seen <= 1'b0;
      rx_chan_ok     <= 1'b0;
    end else begin
      rx_chan        <= rx_chan_next;
      rx_escape      <= rx_escape_next;
      rx_header_seen <= rx_header_seen_next;
      rx_chan_ok     <= rx_chan_ok_next;
    end
  end

endmodule

FILE: src/ebcm_tx.sv
// transmit sequencer: round-robin source pick, start/header/escape/data framing
// depends on ebcm_pkg
module ebcm_tx #(
  parameter int NUM_CHANNELS = ebcm_pkg::NUM_CHANNELS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            src_has_data,
  input  logic [7:0]      src_byte,
  input  logic [7:0]      tx_enable_mask,
  output ebcm_pkg::send_t send,
  output logic [2:0]      query_channel
);

  ebcm_pkg::tx_phase_t tx_phase, tx_phase_next;
  logic [2:0] tx_chan, tx_chan_next;
  logic       tx_escape_pending, tx_escape_pending_next;
  logic [7:0] tx_held_byte, tx_held_byte_next;

  // first enabled channel at or after start, {found, channel}
  function automatic logic [3:0] pick(input logic [2:0] start, input logic [7:0] mask);
    logic [3:0] s4;
    logic [3:0] c4;
    logic [3:0] res;
    res = '0;
    s4  = ({1'b0, start} >= 4'(NUM_CHANNELS)) ? 4'd0 : {1'b0, start};
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      c4 = s4 + 4'(i);
      if (c4 >= 4'(NUM_CHANNELS)) c4 = c4 - 4'(NUM_CHANNELS);
      if (mask[c4[2:0]]) res = {1'b1, c4[2:0]};
    end
    return res;
  endfunction

  always_comb begin
    logic [3:0] pk;
    logic [3:0] nc;
    logic [3:0] qk;
    logic [7:0] c;
    logic       esc;
    tx_phase_next          = tx_phase;
    tx_chan_next           = tx_chan;
    tx_escape_pending_next = tx_escape_pending;
    tx_held_byte_next      = tx_held_byte;
    send                   = '0;
    pk                     = pick(tx_chan, tx_enable_mask);
    nc                     = {1'b0, pk[2:0]} + 4'd1;
    if (nc >= 4'(NUM_CHANNELS)) nc = 4'd0;
    esc = (src_byte == ebcm_pkg::LINK_START) || (src_byte == ebcm_pkg::LINK_ESC);
    c   = esc ? (src_byte ^ ebcm_pkg::ESC_XOR) : src_byte;
    if (step) begin
      unique case (tx_phase)
        ebcm_pkg::TX_HEADER: begin
          send.valid    = 1'b1;
          send.data     = {tx_chan, 5'b0};
          tx_phase_next = ebcm_pkg::TX_DATA;
        end
        ebcm_pkg::TX_DATA: begin
          send.valid = 1'b1;
          if (tx_escape_pending) begin
            send.data              = ebcm_pkg::LINK_ESC;
            tx_escape_pending_next = 1'b0;
          end else begin
            send.data     = tx_held_byte;
            tx_phase_next = ebcm_pkg::TX_OPEN;
          end
        end
        ebcm_pkg::TX_IDLE, ebcm_pkg::TX_OPEN: begin
          if (pk[3]) begin
            if (!src_has_data) begin
              // empty source: move on, close the frame if the channel changes
              if (nc[2:0] != tx_chan) tx_phase_next = ebcm_pkg::TX_IDLE;
              tx_chan_next = nc[2:0];
            end else begin
              tx_escape_pending_next = esc;
              tx_held_byte_next      = c;
              send.valid             = 1'b1;
              if (tx_phase == ebcm_pkg::TX_IDLE || pk[2:0] != tx_chan) begin
                tx_chan_next  = pk[2:0];
                send.data     = ebcm_pkg::LINK_START;
                tx_phase_next = ebcm_pkg::TX_HEADER;
              end else if (esc) begin
                send.data              = ebcm_pkg::LINK_ESC;
                tx_escape_pending_next = 1'b0;
                tx_phase_next          = ebcm_pkg::TX_DATA;
              end else begin
                send.data     = c;
                tx_phase_next = ebcm_pkg::TX_OPEN;
              end
            end
          end
        end
        default: tx_phase_next = tx_phase;
      endcase
    end
    qk            = pick(tx_chan_next, tx_enable_mask);
    query_channel = qk[3] ? qk[2:0] : tx_chan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_phase          <= ebcm_pkg::TX_IDLE;
      tx_chan           <= '0;
      tx_escape_pending <= 1'b0;
      tx_held_byte      <= '0;
    end else begin
      tx_phase          <= tx_phase_next;
      tx_chan           <= tx_chan_next;
      tx_escape_pending <= tx_escape_pending_next;
      tx_held_byte      <= tx_held_byte_next;
    end
  end

endmodule

FILE: src/escaped_byte_channel_mux_core.sv
// flow: a request accepted into the input register is processed and written to the result
// register when that register is empty or being drained, and its result is then on m_tdata
// throughput: one request per cycle while the result stream does not stall
// reset: synchronous rst empties both pipeline registers, clears all framing state,
// sets both enable masks to all ones; no memory, so no clearing pass
`include "escaped_byte_channel_mux_core_macros.svh"
module escaped_byte_channel_mux_core #(
  parameter int NUM_CHANNELS = ebcm_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // link_byte_in[7:0], src_has_data[8], src_byte[16:9], zero pad
  input  logic        s_tuser,   // func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // deliver_valid[0], deliver_channel[3:1], deliver_byte[11:4],
                                 // send_valid[12], send_byte[20:13], query_channel[23:21]
  output logic        m_tuser    // deliver_is_header
);

  // configuration registers
  logic [7:0] rx_enable_mask;
  logic [7:0] tx_enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable_mask <= 8'hFF;
      tx_enable_mask <= 8'hFF;
    end else if (cfg_we) begin
      unique case (ebcm_pkg::reg_index_t'(cfg_index))
        ebcm_pkg::REG_RX_MASK: rx_enable_mask <= cfg_data;
        ebcm_pkg::REG_TX_MASK: tx_enable_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic            in_valid;
  ebcm_pkg::item_t in_item;
  // result register
  logic               out_valid;
  ebcm_pkg::deliver_t out_deliver;
  ebcm_pkg::send_t    out_send;
  logic [2:0]         out_query;

  // the held request moves on when the result register is empty or being drained
  logic advance;
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func         <= s_tuser;
      in_item.link_byte_in <= s_tdata[7:0];
      in_item.src_has_data <= s_tdata[8];
      in_item.src_byte     <= s_tdata[16:9];
    end
  end

  // receive and transmit halves, each steps its own state on its own request kind
  ebcm_pkg::deliver_t deliver;
  ebcm_pkg::send_t    send;
  logic [2:0]         query_channel;

  ebcm_rx #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_rx (
    .clk           (clk),
    .rst           (rst),
    .step          (advance && !in_item.func),
    .link_byte_in  (in_item.link_byte_in),
    .rx_enable_mask(rx_enable_mask),
    .deliver       (deliver)
  );

  ebcm_tx #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_tx (
    .clk           (clk),
    .rst           (rst),
    .step          (advance && in_item.func),
    .src_has_data  (in_item.src_has_data),
    .src_byte      (in_item.src_byte),
    .tx_enable_mask(tx_enable_mask),
    .send          (send),
    .query_channel (query_channel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_deliver <= deliver;
      out_send    <= send;
      out_query   <= query_channel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_query, out_send.data, out_send.valid,
                     out_deliver.data, out_deliver.channel, out_deliver.valid};
  assign m_tuser  = out_deliver.is_header;

  // held request is never dropped while the result side is stalled
  `EBCM_ASSERT(a_hold_request, clk, rst, (in_valid && !advance) |=> in_valid, "request lost")
  // back-pressure upstream only with a request held
  `EBCM_ASSERT_ALWAYS(a_ready_only_when_full, clk, !s_tready |-> in_valid, "ready low while empty")
  // a request never both delivers and sends
  `EBCM_ASSERT(a_one_direction, clk, rst, m_tvalid |-> !(out_deliver.valid && out_send.valid),
               "deliver and send in one result")
  // header flag only comes with a delivered byte
  `EBCM_ASSERT(a_header_delivered, clk, rst, (m_tvalid && m_tuser) |-> out_deliver.valid,
               "header flag without delivery")

endmodule

FILE: tb/sv/escaped_byte_channel_mux_core_tb.sv
// self-checking testbench for escaped_byte_channel_mux_core: deframing, framed transmit
// polls and both enable masks, checked against a cycle-free predictor of the block
// depends on ebcm_pkg and the core RTL only
module escaped_byte_channel_mux_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebcm_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int QUIET_LIMIT = 2000;  // cycles with no request or result moving

  // request kind carried on s_tuser
  typedef enum logic {
    FUNC_LINK_RX  = 1'b0,
    FUNC_TX_POLL  = 1'b1
  } link_func_t;

  // ready patterns of the result stream
  typedef enum logic [1:0] {
    READY_ALWAYS   = 2'd0,
    READY_RANDOM   = 2'd1,
    READY_PERIODIC = 2'd2,
    READY_SPARSE   = 2'd3
  } ready_pattern_t;

  typedef struct packed {
    deliver_t   dlv;
    send_t      snd;
    logic [2:0] query;
  } mux_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'h0;   // link_byte_in[7:0], src_has_data[8], src_byte[16:9], pad
  logic        s_tuser = 1'b0;    // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // deliver_valid[0], deliver_channel[3:1], deliver_byte[11:4],
                                  // send_valid[12], send_byte[20:13], query_channel[23:21]
  logic        m_tuser;           // deliver_is_header

  escaped_byte_channel_mux_core #(
    .NUM_CHANNELS(NCH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and framing state
  logic [7:0] rx_mask_q = 8'hFF;
  logic [7:0] tx_mask_q = 8'hFF;
  logic [2:0] rx_chan_q = '0;
  bit         rx_esc_q = 0;
  bit         rx_hdr_seen_q = 0;
  bit         rx_chan_ok_q = 0;
  logic [2:0] tx_chan_q = '0;
  bit         tx_esc_owed_q = 0;
  tx_phase_t  tx_phase_q = TX_IDLE;
  logic [7:0] tx_held_q = '0;

  mux_result_t mux_result_q[$];   // predicted results, oldest first

  int errors = 0;
  int n_requests = 0;
  int n_link_bytes = 0;
  int n_polls = 0;
  int n_delivered = 0;
  int n_headers = 0;
  int n_sent = 0;
  int n_mask_settings = 0;
  int quiet_cycles = 0;

  // sender pacing
  bit pacing_on = 0;
  int burst_left = 0;

  // result-side stall pattern
  ready_pattern_t ready_mode = READY_ALWAYS;
  int ready_span = 0;

  // first transmit source enabled at or after from, round robin; -1 when none
  function automatic int first_tx_channel(logic [2:0] from);
    int base;
    int c;
    base = (int'(from) < NCH) ? int'(from) : 0;
    for (int i = 0; i < NCH; i++) begin
      c = (base + i) % NCH;
      if (tx_mask_q[c]) return c;
    end
    return -1;
  endfunction

  // advances the predictor by one request and returns the result it must produce
  function automatic mux_result_t predict_mux_step(link_func_t func, logic [7:0] link,
                                                   logic has, logic [7:0] src);
    mux_result_t r;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [2:0]  nc;
    bit          header_now;
    int          ch;
    r = '0;
    if (func == FUNC_LINK_RX) begin
      b = link;
      if (b == LINK_START) begin
        // start of frame: header expected next, any escape is dropped
        rx_hdr_seen_q = 0;
        rx_esc_q = 0;
      end else if (b == LINK_ESC) begin
        rx_esc_q = 1;
      end else begin
        if (rx_esc_q) begin
          b = b ^ ESC_XOR;
          rx_esc_q = 0;
        end
        header_now = 0;
        // bytes before any start also land here and act as a header
        if (!rx_hdr_seen_q) begin
          rx_chan_q = b[7:5];
          rx_chan_ok_q = (int'(rx_chan_q) < NCH);
          rx_hdr_seen_q = 1;
          header_now = 1;
        end
        // a disabled or out-of-range channel swallows the byte, header flag too
        if (rx_chan_ok_q && rx_mask_q[rx_chan_q]) begin
          r.dlv.valid = 1'b1;
          r.dlv.channel = rx_chan_q;
          r.dlv.data = b;
          r.dlv.is_header = header_now;
        end
      end
    end else if (tx_phase_q == TX_HEADER) begin
      r.snd = '{valid: 1'b1, data: {tx_chan_q, 5'b0}};
      tx_phase_q = TX_DATA;
    end else if (tx_phase_q == TX_DATA) begin
      // owed escape goes out first, then the held byte
      r.snd.valid = 1'b1;
      if (tx_esc_owed_q) begin
        r.snd.data = LINK_ESC;
        tx_esc_owed_q = 0;
      end else begin
        r.snd.data = tx_held_q;
        tx_phase_q = TX_OPEN;
      end
    end else begin
      ch = first_tx_channel(tx_chan_q);
      if (ch >= 0) begin
        if (!has) begin
          // nothing offered: move past the queried channel, closing the frame if it leaves
          nc = 3'((ch + 1) % NCH);
          if (nc != tx_chan_q) tx_phase_q = TX_IDLE;
          tx_chan_q = nc;
        end else begin
          c = src;
          if (c == LINK_START || c == LINK_ESC) begin
            tx_esc_owed_q = 1;
            c = c ^ ESC_XOR;
          end else begin
            tx_esc_owed_q = 0;
          end
          tx_held_q = c;
          r.snd.valid = 1'b1;
          if (tx_phase_q == TX_IDLE || ch != int'(tx_chan_q)) begin
            tx_chan_q = 3'(ch);
            r.snd.data = LINK_START;
            tx_phase_q = TX_HEADER;
          end else if (tx_esc_owed_q) begin
            r.snd.data = LINK_ESC;
            tx_esc_owed_q = 0;
            tx_phase_q = TX_DATA;
          end else begin
            r.snd.data = c;
            tx_phase_q = TX_OPEN;
          end
        end
      end
    end
    ch = first_tx_channel(tx_chan_q);
    r.query = (ch < 0) ? tx_chan_q : 3'(ch);
    if (r.dlv.valid) n_delivered++;
    if (r.dlv.is_header) n_headers++;
    if (r.snd.valid) n_sent++;
    return r;
  endfunction

  task automatic idle_cycles(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursts of random length with random gaps, sometimes long gap-free stretches
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 5));
    end else begin
      burst_left--;
    end
  endtask

  // offers one request, waits for the handshake and records the predicted result
  task automatic send_request(link_func_t func, logic [7:0] link, logic has, logic [7:0] src);
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {7'b0, src, has, link};
    do @(posedge clk); while (!s_tready);
    mux_result_q.push_back(predict_mux_step(func, link, has, src));
    n_requests++;
    if (func == FUNC_LINK_RX) n_link_bytes++;
    else n_polls++;
    if (pacing_on) pace();
  endtask

  // unused fields of the request carry random bits
  task automatic send_link_byte(logic [7:0] b);
    send_request(FUNC_LINK_RX, b, 1'($urandom), 8'($urandom));
  endtask

  task automatic send_poll(logic has, logic [7:0] src);
    send_request(FUNC_TX_POLL, 8'($urandom), has, src);
  endtask

  task automatic send_escaped(logic [7:0] b);
    if (b == LINK_START || b == LINK_ESC) begin
      send_link_byte(LINK_ESC);
      send_link_byte(b ^ ESC_XOR);
    end else begin
      send_link_byte(b);
    end
  endtask

  // random byte leaning towards the framing codes and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return LINK_START;
      1:       return LINK_ESC;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // stop sending and wait until every predicted result has come back
  task automatic drain_to_idle();
    s_tvalid <= 1'b0;
    while (mux_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both masks are written back to back while the block is idle
  task automatic set_masks(logic [7:0] rx, logic [7:0] tx);
    drain_to_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_RX_MASK;
    cfg_data <= rx;
    @(posedge clk);
    cfg_index <= REG_TX_MASK;
    cfg_data <= tx;
    @(posedge clk);
    cfg_we <= 1'b0;
    rx_mask_q = rx;
    tx_mask_q = tx;
    n_mask_settings++;
  endtask

  // deframing from reset: byte before any start, headers, escapes, extremes
  task automatic test_rx_deframing();
    send_link_byte(8'h41);        // no start yet, taken as header of channel 2
    send_link_byte(8'h7F);
    send_link_byte(LINK_START);
    send_link_byte(8'hE0);        // header, channel 7
    send_link_byte(8'h00);
    send_link_byte(8'hFF);
    send_escaped(LINK_START);     // escaped start delivered as data
    send_link_byte(LINK_ESC);     // escape cancelled by a start
    send_link_byte(LINK_START);
    send_link_byte(8'hA5);        // header, channel 5
    send_link_byte(LINK_ESC);     // double escape, second one wins
    send_escaped(LINK_ESC);
  endtask

  // polled transmit: start, header, escapes, empty polls moving the round robin
  task automatic test_tx_framing();
    send_poll(1'b1, 8'h55);       // start on channel 0
    send_poll(1'b0, 8'($urandom)); // header owed, source fields ignored
    send_poll(1'b1, 8'($urandom)); // data owed
    send_poll(1'b1, LINK_START);  // same frame, escape then data
    send_poll(1'b0, 8'($urandom));
    send_poll(1'b0, 8'($urandom)); // empty poll closes the frame, moves to channel 1
    send_poll(1'b1, LINK_ESC);    // new frame with escaped byte
    send_poll(1'b1, 8'($urandom));
    send_poll(1'b1, 8'($urandom));
    send_poll(1'b1, 8'($urandom));
    send_poll(1'b1, 8'hFF);
    send_poll(1'b1, 8'h00);
  endtask

  // one round of traffic: well-formed frames and poll runs, some noise and broken frames
  task automatic run_traffic_round(logic [7:0] rx, logic [7:0] tx, int n);
    int stop_at;
    int k;
    set_masks(rx, tx);
    stop_at = n_requests + n;
    while (n_requests < stop_at) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        send_link_byte(LINK_START);
        send_escaped(pick_byte());
        repeat ($urandom_range(0, 6)) send_escaped(pick_byte());
        if ($urandom_range(0, 7) == 0) send_link_byte(LINK_ESC);  // frame cut after escape
      end else if (k < 8) begin
        repeat ($urandom_range(1, 8)) send_poll($urandom_range(0, 3) != 0, pick_byte());
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(link_func_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom),
                       8'($urandom));
      end
    end
  endtask

  // extreme and sparse masks: no receiver, single transmit sources, 5A/A5 and complementary masks
  task automatic test_mask_extremes();
    pacing_on = 1;
    run_traffic_round(8'hFF, 8'hFF, 92);
    run_traffic_round(8'h00, 8'h01, 92);
    run_traffic_round(8'hFF, 8'h80, 92);
    run_traffic_round(8'h5A, 8'hA5, 92);
    run_traffic_round(8'h01, 8'hFE, 92);
    run_traffic_round(8'h80, 8'h7F, 92);
  endtask

  task automatic test_random_traffic();
    pacing_on = 1;
    repeat (3) run_traffic_round(8'($urandom), 8'($urandom_range(1, 255)), 92);
  endtask

  // result stream ready follows its own pattern, changing to a random one when its span runs out
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_pattern_t'($urandom_range(0, 3));
      ready_span <= $urandom_range(20, 120);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      READY_ALWAYS:   m_tready <= 1'b1;
      READY_RANDOM:   m_tready <= ($urandom_range(0, 9) >= 3);
      READY_PERIODIC: m_tready <= (ready_span % 4 != 0);
      default:        m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // every accepted result is compared with the oldest prediction
  always @(posedge clk) begin
    mux_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (mux_result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h/%b", $time, m_tdata, m_tuser);
      end else begin
        want = mux_result_q.pop_front();
        check_field("deliver_valid", 8'(want.dlv.valid), 8'(m_tdata[0]));
        check_field("deliver_channel", 8'(want.dlv.channel), 8'(m_tdata[3:1]));
        check_field("deliver_byte", want.dlv.data, m_tdata[11:4]);
        check_field("deliver_is_header", 8'(want.dlv.is_header), 8'(m_tuser));
        check_field("send_valid", 8'(want.snd.valid), 8'(m_tdata[12]));
        check_field("send_byte", want.snd.data, m_tdata[20:13]);
        check_field("query_channel", 8'(want.query), 8'(m_tdata[23:21]));
      end
    end
  end

  // watchdog: too long with neither a request nor a result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, mux_result_q.size());
      $display("escaped_byte_channel_mux_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_rx_deframing();
    test_tx_framing();
    test_mask_extremes();
    test_random_traffic();
    drain_to_idle();
    repeat (8) @(posedge clk);
    $display("ran %0d requests (%0d link bytes, %0d polls) over %0d mask settings",
             n_requests, n_link_bytes, n_polls, n_mask_settings);
    $display("predicted %0d deliveries (%0d headers) and %0d link bytes sent, %0d errors",
             n_delivered, n_headers, n_sent, errors);
    if (errors == 0) begin
      $display("escaped_byte_channel_mux_core_tb: PASS");
    end else begin
      $display("escaped_byte_channel_mux_core_tb: FAIL");
    end
    $finish;
  end

endmodule
